>>> design/assert_macros.svh
// Assertion macros used by the sample player design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> design/cisp_pkg.sv
// Shared types and constants for the cubic-interpolating sample player.
package cisp_pkg;
  localparam int NumBuffers  = 4;
  localparam int BufSelBits  = 2;
  localparam int AddrBits    = 16;
  localparam int BufferDepth = 65536;
  localparam int FracBits    = 16;
  localparam int SampleBits  = 16;
  localparam int LenBits     = 17;
  localparam int PosBits     = 40;
  localparam int OutBits     = 20;

  localparam logic [2:0] OP_WRITE   = 3'd0;
  localparam logic [2:0] OP_LENGTH  = 3'd1;
  localparam logic [2:0] OP_TICK    = 3'd2;
  localparam logic [2:0] OP_KEY     = 3'd3;
  localparam logic [2:0] OP_RESTART = 3'd4;

  localparam logic [1:0] REG_ENABLED = 2'd0;
  localparam logic [1:0] REG_LOOP    = 2'd1;
  localparam logic [1:0] REG_NOTE    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_HORNER, ST_SCALE, ST_ACCUM, ST_OUT
  } state_t;

  // Operand request from the sequencer to the tap fetch/evaluation unit.
  typedef struct packed {
    logic                      start;
    logic [BufSelBits-1:0]     buf_sel;
    logic [LenBits-1:0]        idx;
    logic [LenBits-1:0]        len;
  } fetch_req_t;
endpackage

>>> design/cubic_interp_sample_player.sv
// A tick result is registered in ST_OUT after ST_READ, ST_HORNER, ST_SCALE and ST_ACCUM for
// each buffer that holds the index (a disabled tick goes straight to ST_OUT); a held result stalls the last step.
// A new tick is taken only once the last one has left ST_OUT; other items one per cycle while idle.
// Each buffer's four taps go through the single registered RAM read port, and all buffers
// share the one 32x17 Horner multiplier.
// Reset (rst_n low, synchronous): lengths zero, position zero, gain 127, enabled on.
`include "assert_macros.svh"
module cubic_interp_sample_player (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [0:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [1:0]  in_buffer_select,
  input  logic [15:0] in_sample_address,
  input  logic signed [15:0] in_sample_value,
  input  logic [16:0] in_buffer_length,
  input  logic [23:0] in_playback_rate,
  input  logic [6:0]  in_note_velocity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [19:0] out_sample_out,
  output logic        out_past_end
);
  localparam int RamAw = cisp_pkg::BufSelBits + cisp_pkg::AddrBits;

  logic enabled_r, loop_r, note_r;
  logic [cisp_pkg::LenBits-1:0] len_r [cisp_pkg::NumBuffers];
  logic [cisp_pkg::PosBits-1:0] pos_r;
  logic [6:0] gain_r;

  cisp_pkg::state_t state_r, state_nxt;
  logic [23:0] rate_r;
  logic [cisp_pkg::BufSelBits-1:0] buf_r;
  logic [2:0] tap_r;        // read issue / capture step
  logic [1:0] hstep_r;      // Horner step
  logic signed [cisp_pkg::SampleBits-1:0] y_r [4];
  logic signed [22:0] d_r [4];
  logic signed [31:0] t_r;
  logic signed [21:0] sum_r;
  logic past_r;

  logic signed [19:0] out_data_r;
  logic out_past_r, out_valid_r;

  logic [cisp_pkg::LenBits-1:0] ipart;
  logic [cisp_pkg::FracBits-1:0] frac;
  assign ipart = (pos_r[cisp_pkg::PosBits-1:cisp_pkg::FracBits] >= 24'(cisp_pkg::BufferDepth))
                 ? cisp_pkg::LenBits'(cisp_pkg::BufferDepth)
                 : pos_r[cisp_pkg::FracBits+cisp_pkg::LenBits-1:cisp_pkg::FracBits];
  assign frac = pos_r[cisp_pkg::FracBits-1:0];

  logic buf_active;
  assign buf_active = (len_r[buf_r] != '0) && (ipart < len_r[buf_r]);

  // tap address, clamped at both ends
  logic [cisp_pkg::LenBits-1:0] tap_idx;
  always_comb begin
    case (tap_r[1:0])
      2'd0:    tap_idx = (ipart == '0) ? '0 : ipart - 1'b1;
      2'd1:    tap_idx = ipart;
      2'd2:    tap_idx = (ipart + 17'd1 < len_r[buf_r]) ? ipart + 17'd1 : len_r[buf_r] - 1'b1;
      default: tap_idx = (ipart + 17'd2 < len_r[buf_r]) ? ipart + 17'd2 : len_r[buf_r] - 1'b1;
    endcase
  end

  logic wr_en;
  logic [RamAw-1:0] wr_addr, rd_addr;
  logic signed [15:0] rd_data;
  logic in_xfer;
  assign in_xfer = in_valid && in_ready;
  assign wr_en = in_xfer && in_opcode == cisp_pkg::OP_WRITE;
  assign wr_addr = {in_buffer_select, in_sample_address};
  assign rd_addr = {buf_r, tap_idx[cisp_pkg::AddrBits-1:0]};

  cisp_sample_ram u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(in_sample_value),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  // Horner step: t = floor(t*f/2^16) + d
  logic signed [48:0] hprod;
  logic signed [31:0] hnext;
  assign hprod = t_r * $signed({1'b0, frac});
  assign hnext = 32'(hprod >>> cisp_pkg::FracBits) + 32'(d_r[2'd2 - hstep_r]);

  // note scaling: floor((t*g+127)/254) via shift after multiply is not exact;
  // use t*g+127, then floor divide by 254 with a reciprocal and correction
  logic signed [39:0] nprod;
  assign nprod = 40'(t_r) * $signed({1'b0, gain_r}) + 40'sd127;

  logic signed [39:0] scaled_r;
  logic signed [39:0] q_est;
  logic signed [64:0] qmul;
  // reciprocal of 254 in 32 fraction bits, rounded up; |t*g+127| stays below 2^28
  localparam logic [31:0] Recip254 = 32'd16909321;
  assign qmul = $signed(scaled_r[31:0]) * $signed({1'b0, Recip254});
  assign q_est = 40'(qmul >>> 32);

  logic signed [39:0] rem;
  assign rem = scaled_r - q_est * 40'sd254;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cisp_pkg::ST_IDLE:
        if (in_xfer && in_opcode == cisp_pkg::OP_TICK && enabled_r) state_nxt = cisp_pkg::ST_READ;
        else if (in_xfer && in_opcode == cisp_pkg::OP_TICK) state_nxt = cisp_pkg::ST_OUT;
      cisp_pkg::ST_READ:
        if (!buf_active) state_nxt = (buf_r == 2'd3) ? cisp_pkg::ST_OUT : cisp_pkg::ST_READ;
        else if (tap_r == 3'd5) state_nxt = cisp_pkg::ST_HORNER;
      cisp_pkg::ST_HORNER:
        if (hstep_r == 2'd2) state_nxt = cisp_pkg::ST_SCALE;
      cisp_pkg::ST_SCALE:  state_nxt = cisp_pkg::ST_ACCUM;
      cisp_pkg::ST_ACCUM:
        state_nxt = (buf_r == 2'd3) ? cisp_pkg::ST_OUT : cisp_pkg::ST_READ;
      cisp_pkg::ST_OUT:
        if (!out_valid_r || out_ready) state_nxt = cisp_pkg::ST_IDLE;
      default: state_nxt = cisp_pkg::ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == cisp_pkg::ST_IDLE);

  logic signed [19:0] sat_sum;
  assign sat_sum = (sum_r > 22'sd524287) ? 20'sh7FFFF :
                   (sum_r < -22'sd524288) ? 20'sh80000 : sum_r[19:0];

  logic [cisp_pkg::PosBits:0] pos_add;
  assign pos_add = {1'b0, pos_r} + 41'(rate_r);

  logic signed [31:0] round_val;
  assign round_val = (t_r + 32'sd1) >>> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cisp_pkg::ST_IDLE;
      enabled_r <= 1'b1; loop_r <= 1'b0; note_r <= 1'b0;
      for (int i = 0; i < cisp_pkg::NumBuffers; i++) len_r[i] <= '0;
      pos_r <= '0; gain_r <= 7'd127;
      out_valid_r <= 1'b0;
      buf_r <= '0; tap_r <= '0; hstep_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready && state_r != cisp_pkg::ST_OUT) out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          cisp_pkg::REG_ENABLED: begin
            enabled_r <= cfg_wdata[0];
            if (cfg_wdata[0] && !note_r) pos_r <= '0;
          end
          cisp_pkg::REG_LOOP: loop_r <= cfg_wdata[0];
          cisp_pkg::REG_NOTE: begin
            if (note_r && !cfg_wdata[0]) pos_r <= '0;
            note_r <= cfg_wdata[0];
          end
          default: ;
        endcase
      end
      case (state_r)
        cisp_pkg::ST_IDLE: if (in_xfer) begin
          case (in_opcode)
            cisp_pkg::OP_LENGTH: len_r[in_buffer_select] <=
              (in_buffer_length > 17'(cisp_pkg::BufferDepth)) ?
              17'(cisp_pkg::BufferDepth) : in_buffer_length;
            cisp_pkg::OP_KEY: begin pos_r <= '0; gain_r <= in_note_velocity; end
            cisp_pkg::OP_RESTART: pos_r <= '0;
            cisp_pkg::OP_TICK: begin
              rate_r <= in_playback_rate; buf_r <= '0; tap_r <= '0;
              sum_r <= '0; past_r <= 1'b1;
            end
            default: ;
          endcase
        end
        cisp_pkg::ST_READ: begin
          if (!buf_active) begin
            buf_r <= buf_r + 1'b1;
          end else begin
            // read issued with tap_r; the registered RAM data is captured under tap_r + 1
            if (tap_r != 3'd0 && tap_r != 3'd5) y_r[tap_r[1:0] - 2'd1] <= rd_data;
            // all four taps held: start Horner at d3
            if (tap_r == 3'd5) begin
              t_r <= 32'(d_r[3]);
              tap_r <= '0; hstep_r <= '0; past_r <= 1'b0;
            end else tap_r <= tap_r + 1'b1;
          end
        end
        cisp_pkg::ST_HORNER: begin
          t_r <= hnext;
          hstep_r <= hstep_r + 1'b1;
        end
        cisp_pkg::ST_SCALE: scaled_r <= nprod;
        cisp_pkg::ST_ACCUM: begin
          sum_r <= sum_r + 22'(note_r ? ((rem < 0) ? q_est - 40'sd1 :
                   (rem >= 40'sd254) ? q_est + 40'sd1 : q_est) : 40'(round_val));
          buf_r <= buf_r + 1'b1;
        end
        cisp_pkg::ST_OUT: if (!out_valid_r || out_ready) begin
          out_valid_r <= 1'b1;
          out_data_r <= enabled_r ? sat_sum : '0;
          out_past_r <= enabled_r ? past_r : 1'b0;
          if (enabled_r) begin
            if (past_r && !note_r && loop_r) pos_r <= '0;
            else pos_r <= pos_add[cisp_pkg::PosBits] ? '1 : pos_add[cisp_pkg::PosBits-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // coefficients (doubled) from the four taps; t starts at d3
  always_comb begin
    d_r[0] = 23'(2 * 32'(y_r[1]));
    d_r[1] = 23'(32'(y_r[2]) - 32'(y_r[0]));
    d_r[2] = 23'(2 * 32'(y_r[0]) - 5 * 32'(y_r[1]) + 4 * 32'(y_r[2]) - 32'(y_r[3]));
    d_r[3] = 23'(-32'(y_r[0]) + 3 * 32'(y_r[1]) - 3 * 32'(y_r[2]) + 32'(y_r[3]));
  end

  assign out_valid = out_valid_r;
  assign out_sample_out = out_data_r;
  assign out_past_end = out_past_r;

  `CHK_IMPLY(a_ready_idle, clk, rst_n, in_ready, state_r == cisp_pkg::ST_IDLE, "ready outside idle")
  `CHK_NEXT(a_hold_out, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_sample_out), "result dropped")
  `CHK_IMPLY(a_disabled_zero, clk, rst_n, out_valid && !enabled_r && $rose(out_valid), out_sample_out == 20'sd0, "disabled tick nonzero")
endmodule

>>> design/cisp_sample_ram.sv
// Sample memory for all buffers: one write port, one registered read port.
module cisp_sample_ram (
  input  logic                                           clk,
  input  logic                                           wr_en,
  input  logic [cisp_pkg::BufSelBits+cisp_pkg::AddrBits-1:0] wr_addr,
  input  logic signed [cisp_pkg::SampleBits-1:0]         wr_data,
  input  logic [cisp_pkg::BufSelBits+cisp_pkg::AddrBits-1:0] rd_addr,
  output logic signed [cisp_pkg::SampleBits-1:0]         rd_data
);
  logic signed [cisp_pkg::SampleBits-1:0] mem [cisp_pkg::NumBuffers*cisp_pkg::BufferDepth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the cubic-interpolating sample player.
module tb_top;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int IdleLimit  = 20000;
  localparam int SettleCycles = 100;
  localparam longint OutHi = (64'sd1 <<< (cisp_pkg::OutBits - 1)) - 1;
  localparam longint OutLo = -(64'sd1 <<< (cisp_pkg::OutBits - 1));

  typedef struct packed {
    logic [2:0]         op;
    logic [1:0]         sel;
    logic [15:0]        addr;
    logic signed [15:0] val;
    logic [16:0]        len;
    logic [23:0]        rate;
    logic [6:0]         vel;
  } player_item_t;

  typedef struct packed {
    logic signed [19:0] sample;
    logic               past;
  } player_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [0:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_opcode = '0;
  logic [1:0] in_buffer_select = '0;
  logic [15:0] in_sample_address = '0;
  logic signed [15:0] in_sample_value = '0;
  logic [16:0] in_buffer_length = '0;
  logic [23:0] in_playback_rate = '0;
  logic [6:0] in_note_velocity = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [19:0] out_sample_out;
  logic out_past_end;

  cubic_interp_sample_player dut (.*);

  always #5 clk = ~clk;

  // Predictor state
  int                           smem[int];
  int                           filled[cisp_pkg::NumBuffers];
  logic [cisp_pkg::LenBits-1:0] p_len[cisp_pkg::NumBuffers];
  logic [cisp_pkg::PosBits-1:0] p_pos;
  logic [6:0]                   p_gain;
  logic                         p_enabled, p_loop, p_note;
  player_out_t                  pending_outputs[$];

  int  errors = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;
  int  stall_left = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint floor_div(longint x, longint d);
    longint q;
    q = x / d;
    if ((x % d) != 0 && x < 0) q--;
    return q;
  endfunction

  function automatic longint tap(int b, int a);
    if (!smem.exists(b * cisp_pkg::BufferDepth + a)) begin
      $error("tap read of unwritten entry buffer %0d addr %0d", b, a);
      errors++;
      return 0;
    end
    return smem[b * cisp_pkg::BufferDepth + a];
  endfunction

  function automatic longint cubic_value(int b, int idx, int len, longint f);
    longint y0, y1, y2, y3, d0, d1, d2, d3, t;
    y0 = tap(b, idx == 0 ? 0 : idx - 1);
    y1 = tap(b, idx);
    y2 = tap(b, (idx + 1 < len) ? idx + 1 : len - 1);
    y3 = tap(b, (idx + 2 < len) ? idx + 2 : len - 1);
    d0 = 2 * y1;
    d1 = y2 - y0;
    d2 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
    d3 = -y0 + 3 * y1 - 3 * y2 + y3;
    t = d3;
    t = floor_div(t * f, 64'sd1 <<< cisp_pkg::FracBits) + d2;
    t = floor_div(t * f, 64'sd1 <<< cisp_pkg::FracBits) + d1;
    t = floor_div(t * f, 64'sd1 <<< cisp_pkg::FracBits) + d0;
    if (p_note) return floor_div(t * longint'(p_gain) + 127, 254);
    return floor_div(t + 1, 2);
  endfunction

  function automatic void store_sample(int b, int a, logic signed [15:0] v);
    smem[b * cisp_pkg::BufferDepth + a] = int'(v);
    while (filled[b] < cisp_pkg::BufferDepth &&
           smem.exists(b * cisp_pkg::BufferDepth + filled[b]))
      filled[b]++;
  endfunction

  function automatic void player_reset();
    smem.delete();
    for (int b = 0; b < cisp_pkg::NumBuffers; b++) begin
      filled[b] = 0;
      p_len[b] = '0;
    end
    p_pos = '0;
    p_gain = 7'd127;
    p_enabled = 1'b1;
    p_loop = 1'b0;
    p_note = 1'b0;
  endfunction

  function automatic void player_config(logic [1:0] idx, logic v);
    case (idx)
      cisp_pkg::REG_ENABLED: begin
        p_enabled = v;
        if (p_enabled && !p_note) p_pos = '0;
      end
      cisp_pkg::REG_LOOP: p_loop = v;
      cisp_pkg::REG_NOTE: begin
        if (p_note && !v) p_pos = '0;
        p_note = v;
      end
      default: ;
    endcase
  endfunction

  function automatic void player_step(player_item_t it);
    longint ipart, f, sum;
    bit past;
    logic [cisp_pkg::PosBits:0] next_pos;
    player_out_t res;
    case (it.op)
      cisp_pkg::OP_WRITE: store_sample(int'(it.sel), int'(it.addr), it.val);
      cisp_pkg::OP_LENGTH:
        p_len[it.sel] = (it.len > cisp_pkg::BufferDepth) ?
                        cisp_pkg::LenBits'(cisp_pkg::BufferDepth) : it.len;
      cisp_pkg::OP_KEY: begin
        p_pos = '0;
        p_gain = it.vel;
      end
      cisp_pkg::OP_RESTART: p_pos = '0;
      cisp_pkg::OP_TICK: begin
        if (!p_enabled) begin
          res = '0;
        end else begin
          ipart = longint'(p_pos >> cisp_pkg::FracBits);
          f = longint'(p_pos[cisp_pkg::FracBits-1:0]);
          sum = 0;
          past = 1'b1;
          for (int b = 0; b < cisp_pkg::NumBuffers; b++) begin
            if (p_len[b] != 0 && ipart < longint'(p_len[b])) begin
              past = 1'b0;
              sum += cubic_value(b, int'(ipart), int'(p_len[b]), f);
            end
          end
          if (sum > OutHi) sum = OutHi;
          if (sum < OutLo) sum = OutLo;
          res.sample = sum[19:0];
          res.past = past;
          if (past && !p_note && p_loop) begin
            p_pos = '0;
          end else begin
            next_pos = {1'b0, p_pos} + 41'(it.rate);
            p_pos = next_pos[cisp_pkg::PosBits] ? '1 : next_pos[cisp_pkg::PosBits-1:0];
          end
        end
        pending_outputs.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // Result checker and watchdog
  always @(posedge clk) begin
    player_out_t exp_out;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        if (pending_outputs.size() == 0) begin
          $error("result with nothing expected: sample_out %0d", out_sample_out);
          errors++;
        end else begin
          exp_out = pending_outputs.pop_front();
          if (out_sample_out !== exp_out.sample) begin
            $error("sample_out expected %0d actual %0d", exp_out.sample, out_sample_out);
            errors++;
          end
          if (out_past_end !== exp_out.past) begin
            $error("past_end expected %0d actual %0d", exp_out.past, out_past_end);
            errors++;
          end
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    int g;
    if (quiet) begin
      out_ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      g = pick_gap();
      out_ready <= (g == 0);
      if (g > 0) stall_left = g - 1;
    end
  end

  task automatic send_item(player_item_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode <= it.op;
    in_buffer_select <= it.sel;
    in_sample_address <= it.addr;
    in_sample_value <= it.val;
    in_buffer_length <= it.len;
    in_playback_rate <= it.rate;
    in_note_velocity <= it.vel;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    player_step(it);
  endtask

  task automatic send_op(logic [2:0] op, logic [1:0] sel = '0, logic [15:0] addr = '0,
                         logic [15:0] val = '0, logic [16:0] len = '0,
                         logic [23:0] rate = '0, logic [6:0] vel = '0);
    player_item_t it;
    it = '{op: op, sel: sel, addr: addr, val: val, len: len, rate: rate, vel: vel};
    send_item(it);
  endtask

  task automatic tick(logic [23:0] rate);
    send_op(cisp_pkg::OP_TICK, '0, '0, '0, '0, rate);
  endtask

  task automatic set_length(logic [1:0] sel, logic [16:0] len);
    send_op(cisp_pkg::OP_LENGTH, sel, '0, '0, len);
  endtask

  // Drop valid and let the block drain, including items with no result.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    player_config(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic fill_buffer(int b, int n);
    logic [15:0] v;
    for (int a = 0; a < n; a++) begin
      v = (a == 0) ? 16'h8000 : (a == 1) ? 16'h7fff : 16'($urandom());
      send_op(cisp_pkg::OP_WRITE, 2'(b), 16'(a), v);
    end
  endtask

  task automatic test_directed();
    tick(24'h010000);                               // nothing connected
    for (int b = 0; b < 3; b++) fill_buffer(b, 64);
    set_length(2'd0, 17'd1);
    send_op(cisp_pkg::OP_RESTART);
    tick(24'h008000);                               // single sample, clamp both ends
    tick(24'h0);
    set_length(2'd0, 17'd64);
    set_length(2'd1, 17'd64);
    set_length(2'd2, 17'd64);
    send_op(cisp_pkg::OP_RESTART);
    repeat (3) tick(24'h018000);
    tick(24'h000001);
    send_op(cisp_pkg::OP_KEY, '0, '0, '0, '0, '0, 7'd0);
    drain();
    write_reg(cisp_pkg::REG_NOTE, 1'b1);
    repeat (2) tick(24'h00c000);
    send_op(cisp_pkg::OP_KEY, '0, '0, '0, '0, '0, 7'd127);
    tick(24'h00c000);
    drain();
    write_reg(cisp_pkg::REG_NOTE, 1'b0);            // leaving note mode resets position
    tick(24'h004000);
    drain();
    write_reg(cisp_pkg::REG_LOOP, 1'b1);
    set_length(2'd0, 17'd2);
    set_length(2'd1, 17'd0);
    set_length(2'd2, 17'd0);
    repeat (4) tick(24'hffffff);                    // run past the end and wrap
    drain();
    write_reg(cisp_pkg::REG_ENABLED, 1'b0);
    tick(24'h010000);
    drain();
    write_reg(cisp_pkg::REG_ENABLED, 1'b1);
    tick(24'h010000);
    for (int op = int'(OP_UNUSED_LO); op <= int'(OP_UNUSED_HI); op++)
      send_op(3'(op), 2'd3, '0, '0, '0, 24'hffffff);
    drain();
    write_reg(cisp_pkg::REG_LOOP, 1'b0);
  endtask

  // Oversized and full-depth lengths on a short written prefix near index zero.
  task automatic test_length_clamp();
    fill_buffer(3, 4);
    for (int b = 0; b < 3; b++) set_length(2'(b), 17'd0);
    set_length(2'd3, 17'h1ffff);
    send_op(cisp_pkg::OP_RESTART);
    repeat (4) tick(24'h008000);
    set_length(2'd3, 17'h10000);
    send_op(cisp_pkg::OP_RESTART);
    repeat (3) tick(24'h008000);
    set_length(2'd3, 17'd0);
    send_op(cisp_pkg::OP_RESTART);
    drain();
  endtask

  task automatic test_random(int total);
    player_item_t it;
    int count, r, lim;
    count = 0;
    while (count < total) begin
      quiet = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < 65 && count < total; k++) begin
        it.sel = 2'($urandom());
        it.addr = 16'($urandom());
        it.val = 16'($urandom());
        it.len = 17'($urandom());
        it.rate = 24'($urandom());
        it.vel = 7'($urandom());
        r = $urandom_range(0, 99);
        count++;
        if (r < 25) begin
          it.op = cisp_pkg::OP_WRITE;
          if ($urandom_range(0, 4) != 0) it.addr = 16'($urandom_range(0, 95));
        end else if (r < 35) begin
          // keep every connected index on written entries
          it.op = cisp_pkg::OP_LENGTH;
          lim = (filled[it.sel] > 96) ? 96 : filled[it.sel];
          it.len = 17'($urandom_range(0, lim));
        end else if (r < 85) begin
          it.op = cisp_pkg::OP_TICK;
          if ($urandom_range(0, 9) != 0) it.rate = 24'($urandom_range(0, 24'h030000));
        end else if (r < 92) begin
          it.op = cisp_pkg::OP_KEY;
        end else if (r < 97) begin
          it.op = cisp_pkg::OP_RESTART;
        end else begin
          it.op = 3'($urandom_range(int'(OP_UNUSED_LO), int'(OP_UNUSED_HI)));
          count--;
        end
        send_item(it);
      end
      drain();
      write_reg(cisp_pkg::REG_ENABLED, ($urandom_range(0, 3) != 0));
      write_reg(cisp_pkg::REG_LOOP, 1'($urandom()));
      write_reg(cisp_pkg::REG_NOTE, 1'($urandom()));
    end
  endtask

  initial begin
    player_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_length_clamp();
    test_random(400);
    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
